/* rtl/core/lpcp_pkg.sv */
`default_nettype none
package lpcp_pkg;

  typedef enum logic [3:0] {
    CfgRow0Cols01 = 4'd0,
    CfgRow0Cols23 = 4'd1,
    CfgRow1Cols01 = 4'd2,
    CfgRow1Cols23 = 4'd3,
    CfgRow2Cols01 = 4'd4,
    CfgRow2Cols23 = 4'd5,
    CfgWidthLimit = 4'd6,
    CfgHeightLimit = 4'd7
  } cfg_idx_e;

  localparam int unsigned NumCoefRegs = 6;
  localparam int unsigned LimitW = 12;
  localparam int unsigned ShadeW = 7;
  localparam int unsigned QuotBits = 12;
  localparam logic [LimitW-1:0] ResetWidthLimit = 12'd1400;
  localparam logic [LimitW-1:0] ResetHeightLimit = 12'd1000;
  localparam int unsigned ShadeCenter = 20;
  localparam int unsigned ShadeScale = 255;
  localparam int unsigned ShadeDrop = 100;
  // shade = t / 20 as (t * 3277) >> 16, exact for t below 2020
  localparam int unsigned ShadeLimitT = (ShadeDrop + 1) * ShadeCenter;
  localparam logic [11:0] ShadeRecip = 12'd3277;
  localparam int unsigned ShadeRecipShift = 16;

endpackage
`default_nettype wire

/* rtl/core/lidar_point_camera_projection.sv */
// LiDAR point to camera pixel projection.
// s_axis: one point per item, tdata = {z, y, x}, 32 bits each, signed fixed point.
// m_axis: one result per kept point, tdata = {0, shade, pixel_row, pixel_col}.
// cfg: write channel, cfg_index_i selects the register, cfg_data_i holds the value;
//   always ready. Write only while no item is in flight.
// Dropped points (depth not positive, pixel out of range, shade above 100)
// give no output item.
// Pipeline: one multiply stage, one sum stage, one check stage and a 13
// stage restoring divider; its top stage drops too wide quotients, each
// other stage retires one quotient bit for column and row in parallel.
// Throughput: one point per cycle; each stage holds a valid bit and only
// stalls when the stage after it is full and blocked, so bubbles collapse.
// Reset clears all valid bits, the matrix to zero and the limits to
// 1400 by 1000. When m_axis_tready is low the output holds and the pipe
// keeps filling until full, then s_axis_tready drops.
`default_nettype none
module lidar_point_camera_projection #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // point_x, point_y, point_z
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_col, pixel_row, shade, zero pad
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [3:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);
  import lpcp_pkg::*;

  localparam int unsigned PW    = COORD_WIDTH + 32;
  localparam int unsigned SHW   = PW - FRAC_BITS;
  localparam int unsigned SUMW  = ((SHW > 32) ? SHW : 32) + 2;
  localparam int unsigned WW    = SUMW + QuotBits;
  localparam int unsigned CW6   = FRAC_BITS + 6;
  localparam int unsigned DW    = ((COORD_WIDTH > CW6) ? COORD_WIDTH : CW6) + 1;
  localparam int unsigned TW    = DW + 8 - FRAC_BITS;
  localparam int unsigned NDiv  = QuotBits + 1;

  // configuration
  logic [63:0]       coef_q [NumCoefRegs];
  logic [LimitW-1:0] wl_q, hl_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoefRegs; i++) coef_q[i] <= '0;
      wl_q <= ResetWidthLimit;
      hl_q <= ResetHeightLimit;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRow0Cols01:  coef_q[0] <= cfg_data_i;
        CfgRow0Cols23:  coef_q[1] <= cfg_data_i;
        CfgRow1Cols01:  coef_q[2] <= cfg_data_i;
        CfgRow1Cols23:  coef_q[3] <= cfg_data_i;
        CfgRow2Cols01:  coef_q[4] <= cfg_data_i;
        CfgRow2Cols23:  coef_q[5] <= cfg_data_i;
        CfgWidthLimit:  wl_q <= cfg_data_i[LimitW-1:0];
        CfgHeightLimit: hl_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // handshake enables
  logic             v1_q, v2_q, v3_q;
  logic             dvv_q [NDiv];
  logic             en1, en2, en3;
  logic [NDiv-1:0]  den;

  always_comb begin
    den[0] = !dvv_q[0] || m_axis_tready;
    for (int k = 1; k < NDiv; k++) den[k] = !dvv_q[k] || den[k-1];
    en3 = !v3_q || den[NDiv-1];
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign s_axis_tready = en1;

  // stage 1: products and distance
  logic signed [COORD_WIDTH-1:0] px, py, pz;
  logic signed [PW-1:0]          prod_d [9];
  logic signed [PW-1:0]          prod_q [9];
  logic signed [DW-1:0]          xd;
  logic [DW-1:0]                 dist_d, dist_q;

  assign px = $signed(s_axis_tdata[COORD_WIDTH-1:0]);
  assign py = $signed(s_axis_tdata[32+COORD_WIDTH-1:32]);
  assign pz = $signed(s_axis_tdata[64+COORD_WIDTH-1:64]);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_d[3*r]   = $signed(coef_q[2*r][31:0])    * px;
      prod_d[3*r+1] = $signed(coef_q[2*r][63:32])   * py;
      prod_d[3*r+2] = $signed(coef_q[2*r+1][31:0])  * pz;
    end
    xd = DW'(px) - $signed(DW'(ShadeCenter) << FRAC_BITS);
    dist_d = xd[DW-1] ? DW'(-xd) : DW'(xd);
  end

  // stage 2: row sums and scaled distance
  logic signed [SUMW-1:0] sum_d [3];
  logic signed [SUMW-1:0] sum_q [3];
  logic [DW+7:0]          tprod;
  logic [TW-1:0]          t_d, t_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SUMW'(prod_q[3*r]   >>> FRAC_BITS)
               + SUMW'(prod_q[3*r+1] >>> FRAC_BITS)
               + SUMW'(prod_q[3*r+2] >>> FRAC_BITS)
               + SUMW'($signed(coef_q[2*r+1][63:32]));
    end
    tprod = (DW+8)'(dist_q) * (DW+8)'(ShadeScale);
    t_d = TW'(tprod >> FRAC_BITS);
  end

  // stage 3: sign handling, depth and shade checks
  logic                   keep3;
  logic [SUMW-1:0]        ru3_d, rv3_d, w3_d;
  logic [SUMW-1:0]        ru3_q, rv3_q, w3_q;
  logic [ShadeW-1:0]      sh3_d, sh3_q;
  logic signed [SUMW:0]   uw_sum, vw_sum;
  logic [22:0]            shp;

  always_comb begin
    uw_sum = (SUMW+1)'(sum_q[0]) + (SUMW+1)'(sum_q[2]);
    vw_sum = (SUMW+1)'(sum_q[1]) + (SUMW+1)'(sum_q[2]);
    keep3 = (sum_q[2] > 0)
         && (!sum_q[0][SUMW-1] || uw_sum > 0)
         && (!sum_q[1][SUMW-1] || vw_sum > 0)
         && (t_q < TW'(ShadeLimitT));
    ru3_d = sum_q[0][SUMW-1] ? '0 : SUMW'(sum_q[0]);
    rv3_d = sum_q[1][SUMW-1] ? '0 : SUMW'(sum_q[1]);
    w3_d  = SUMW'(sum_q[2]);
    shp   = 23'(t_q[10:0]) * 23'(ShadeRecip);
    sh3_d = shp[ShadeRecipShift +: ShadeW];
  end

  // divider stages, stage k below 12 decides quotient bit k, stage 12 drops overflows; stage 0 is the output
  logic [SUMW-1:0]     dru_q [NDiv];
  logic [SUMW-1:0]     drv_q [NDiv];
  logic [SUMW-1:0]     dw_q  [NDiv];
  logic [QuotBits-1:0] dqu_q [NDiv];
  logic [QuotBits-1:0] dqv_q [NDiv];
  logic [ShadeW-1:0]   dsh_q [NDiv];

  logic                sv   [NDiv];
  logic [SUMW-1:0]     sru  [NDiv];
  logic [SUMW-1:0]     srv  [NDiv];
  logic [SUMW-1:0]     sw   [NDiv];
  logic [QuotBits-1:0] squ  [NDiv];
  logic [QuotBits-1:0] sqv  [NDiv];
  logic [ShadeW-1:0]   ssh  [NDiv];

  logic                nv   [NDiv];
  logic [SUMW-1:0]     nru  [NDiv];
  logic [SUMW-1:0]     nrv  [NDiv];
  logic [QuotBits-1:0] nqu  [NDiv];
  logic [QuotBits-1:0] nqv  [NDiv];
  logic [WW-1:0]       wsh  [NDiv];
  logic                geu  [NDiv];
  logic                gev  [NDiv];

  always_comb begin
    sv[NDiv-1]  = v3_q;
    sru[NDiv-1] = ru3_q;
    srv[NDiv-1] = rv3_q;
    sw[NDiv-1]  = w3_q;
    squ[NDiv-1] = '0;
    sqv[NDiv-1] = '0;
    ssh[NDiv-1] = sh3_q;
    for (int k = 0; k < NDiv-1; k++) begin
      sv[k]  = dvv_q[k+1];
      sru[k] = dru_q[k+1];
      srv[k] = drv_q[k+1];
      sw[k]  = dw_q[k+1];
      squ[k] = dqu_q[k+1];
      sqv[k] = dqv_q[k+1];
      ssh[k] = dsh_q[k+1];
    end
    for (int k = 0; k < NDiv; k++) begin
      wsh[k] = WW'(sw[k]) << k;
      geu[k] = WW'(sru[k]) >= wsh[k];
      gev[k] = WW'(srv[k]) >= wsh[k];
      nru[k] = geu[k] ? SUMW'(WW'(sru[k]) - wsh[k]) : sru[k];
      nrv[k] = gev[k] ? SUMW'(WW'(srv[k]) - wsh[k]) : srv[k];
      nqu[k] = squ[k];
      nqv[k] = sqv[k];
      if (k == NDiv-1) begin
        nv[k] = sv[k] && !geu[k] && !gev[k];
      end else begin
        nqu[k][k] = geu[k];
        nqv[k][k] = gev[k];
        nv[k] = sv[k];
      end
      if (k == 0) nv[k] = sv[k] && (nqu[k] <= wl_q) && (nqv[k] <= hl_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int k = 0; k < NDiv; k++) dvv_q[k] <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q && keep3;
      for (int k = 0; k < NDiv; k++) begin
        if (den[k]) dvv_q[k] <= nv[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 9; i++) prod_q[i] <= prod_d[i];
      dist_q <= dist_d;
    end
    if (en2) begin
      for (int r = 0; r < 3; r++) sum_q[r] <= sum_d[r];
      t_q <= t_d;
    end
    if (en3) begin
      ru3_q <= ru3_d;
      rv3_q <= rv3_d;
      w3_q  <= w3_d;
      sh3_q <= sh3_d;
    end
    for (int k = 0; k < NDiv; k++) begin
      if (den[k]) begin
        dru_q[k] <= nru[k];
        drv_q[k] <= nrv[k];
        dw_q[k]  <= sw[k];
        dqu_q[k] <= nqu[k];
        dqv_q[k] <= nqv[k];
        dsh_q[k] <= ssh[k];
      end
    end
  end

  assign m_axis_tvalid = dvv_q[0];
  assign m_axis_tdata  = {1'b0, dsh_q[0], dqv_q[0], dqu_q[0]};

endmodule
`default_nettype wire

/* rtl/core/lpcp_checker.sv */
`default_nettype none
module lpcp_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready
);
  import lpcp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_shade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[30:24] <= 7'(ShadeDrop) && !m_axis_tdata[31])
    else $error("shade out of range");

  a_no_out_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && $past(!m_axis_tvalid) && $past(!s_axis_tvalid) |-> s_axis_tready)
    else $error("input blocked while output side is idle");

endmodule

bind lidar_point_camera_projection lpcp_checker u_lpcp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready)
);
`default_nettype wire
